// ===== sv/gpsd_pkg.sv =====
// Shared types and constants for the Gray-code pattern stack decoder.
`default_nettype none

package gpsd_pkg;

  // Field and counter widths
  localparam int SampleW  = 8;
  localparam int PixW     = 20;
  localparam int FrameW   = PixW + 1;
  localparam int PlaneW   = 4;
  localparam int PlanesW  = PlaneW + 1;
  localparam int CodeW    = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = FrameW;
  localparam int Depth    = 1 << PixW;

  // Limits and reset values of the configuration registers
  localparam logic [PlanesW-1:0] MaxPlanes     = PlanesW'(16);
  localparam logic [PlanesW-1:0] PlanesReset   = PlanesW'(10);
  localparam logic [FrameW-1:0]  MaxPixels     = FrameW'(Depth);
  localparam logic [FrameW-1:0]  FrameReset    = FrameW'(Depth);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgNumPlanes   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFramePixels = CfgIdxW'(1);

  typedef struct packed {
    logic [SampleW-1:0] pattern_sample;
    logic [SampleW-1:0] inverse_sample;
  } gpsd_in_t;

  typedef struct packed {
    logic [PixW-1:0]  pixel_index;
    logic [CodeW-1:0] code_index;
  } gpsd_out_t;

  // Per-pixel stored state: running binary bit and partial index
  typedef struct packed {
    logic             bin;
    logic [CodeW-1:0] idx;
  } gpsd_entry_t;

  // Position of the next transaction within the stack
  typedef struct packed {
    logic [PixW-1:0]  pix;
    logic             first_plane;
    logic             last_plane;
    logic [CodeW-1:0] weight;
  } gpsd_info_t;

endpackage

`default_nettype wire

// ===== sv/gpsd_seq.sv =====
// Configuration registers and pixel/plane counters of the decoder.
`default_nettype none

module gpsd_seq
  import gpsd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                advance_i,
  output gpsd_info_t               info_o
);

  logic [PlanesW-1:0] planes_q;
  logic [FrameW-1:0]  frame_q;
  logic [PixW-1:0]    pix_q, pix_d;
  logic [PlaneW-1:0]  plane_q, plane_d;

  logic [PlanesW-1:0] planes_eff;
  logic [FrameW-1:0]  frame_eff;
  logic [PixW-1:0]    pix_cur;
  logic [PlaneW-1:0]  plane_cur;
  logic [FrameW-1:0]  pix_inc;
  logic [PlanesW-1:0] plane_inc;
  logic [PlanesW-1:0] shift;

  // Clamp register values into their legal ranges
  always_comb begin
    planes_eff = planes_q;
    if (planes_q == '0) planes_eff = PlanesW'(1);
    else if (planes_q > MaxPlanes) planes_eff = MaxPlanes;
    frame_eff = frame_q;
    if (frame_q == '0) frame_eff = FrameW'(1);
    else if (frame_q > MaxPixels) frame_eff = MaxPixels;
  end

  // Current position, next position and plane weight
  always_comb begin
    pix_cur   = ({1'b0, pix_q} >= frame_eff) ? '0 : pix_q;
    plane_cur = ({1'b0, plane_q} >= planes_eff) ? '0 : plane_q;
    pix_inc   = {1'b0, pix_cur} + FrameW'(1);
    plane_inc = {1'b0, plane_cur} + PlanesW'(1);
    shift     = planes_eff - plane_inc;
    if (pix_inc >= frame_eff) begin
      pix_d   = '0;
      plane_d = (plane_inc >= planes_eff) ? '0 : plane_inc[PlaneW-1:0];
    end else begin
      pix_d   = pix_inc[PixW-1:0];
      plane_d = plane_cur;
    end
    info_o.pix         = pix_cur;
    info_o.first_plane = (plane_cur == '0);
    info_o.last_plane  = (plane_inc == planes_eff);
    info_o.weight      = CodeW'(1) << shift[PlaneW-1:0];
  end

  // Register writes restart the stack; with no write presented, step on each transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planes_q <= PlanesReset;
      frame_q  <= FrameReset;
      pix_q    <= '0;
      plane_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNumPlanes: begin
          planes_q <= cfg_wdata_i[PlanesW-1:0];
          pix_q    <= '0;
          plane_q  <= '0;
        end
        CfgFramePixels: begin
          frame_q <= cfg_wdata_i;
          pix_q   <= '0;
          plane_q <= '0;
        end
        default: ;
      endcase
    end else if (advance_i) begin
      pix_q   <= pix_d;
      plane_q <= plane_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gpsd_store.sv =====
// Per-pixel state memory with registered read and write-to-read bypass.
`default_nettype none

module gpsd_store
  import gpsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rd_en_i,
  input  wire logic [PixW-1:0] rd_addr_i,
  output gpsd_entry_t      rd_data_o,
  input  wire logic        wr_en_i,
  input  wire logic [PixW-1:0] wr_addr_i,
  input  wire gpsd_entry_t wr_data_i
);

  gpsd_entry_t mem [Depth];
  gpsd_entry_t rd_q;
  gpsd_entry_t fwd_data_q;
  logic        fwd_q;

  // Single write port, single registered read port (read-before-write)
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_q <= mem[rd_addr_i];
  end

  // Catch a write landing on the address being read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) fwd_data_q <= wr_data_i;
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

`default_nettype wire

// ===== sv/gray_pattern_stack_decoder_unit.sv =====
// Top level of the Gray-code pattern stack decoder.
// Decodes a stack of structured-light Gray-code planes into a per-pixel code
// index. Pixel pairs arrive in raster order, one frame per plane, most
// significant plane first; on the last plane each pixel's finished index is
// returned with its raster position. One transaction is taken every clock
// unless a last-plane one waits on a pending result; each is registered in
// the input stage, then a finished result goes to the output register. The
// per-pixel state memory sets throughput, with one read and one write each
// cycle in a two-step read-then-update pipeline. The state memory holds no
// reset value and needs no clearing pass, since the first plane writes every
// pixel before later planes read it. Any register write restarts the stack.
`default_nettype none

module gray_pattern_stack_decoder_unit
  import gpsd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire gpsd_in_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output gpsd_out_t                out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  gpsd_info_t  info;
  gpsd_info_t  s1_info_q;
  logic        s1_gray_q;
  logic        s1_valid_q;
  logic        s1_adv;
  logic        accept;
  gpsd_entry_t rd_entry;
  gpsd_entry_t upd_entry;
  logic [CodeW-1:0] base_idx;
  logic        out_valid_q;
  gpsd_out_t   out_q;

  assign s1_adv     = s1_valid_q && (!s1_info_q.last_plane || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  gpsd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (accept),
    .info_o      (info)
  );

  gpsd_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (info.pix),
    .rd_data_o (rd_entry),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_info_q.pix),
    .wr_data_i (upd_entry)
  );

  // Input stage: threshold the pair and capture the position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= info;
      s1_gray_q <= (in_data_i.pattern_sample > in_data_i.inverse_sample);
    end
  end

  // Gray to binary and weighted accumulate
  always_comb begin
    upd_entry.bin = s1_info_q.first_plane ? s1_gray_q : (rd_entry.bin ^ s1_gray_q);
    base_idx      = s1_info_q.first_plane ? '0 : rd_entry.idx;
    upd_entry.idx = base_idx + (upd_entry.bin ? s1_info_q.weight : '0);
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_info_q.last_plane) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_info_q.last_plane) begin
      out_q.pixel_index <= s1_info_q.pix;
      out_q.code_index  <= upd_entry.idx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A register write always restarts at pixel zero of the first plane
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == CfgNumPlanes || cfg_idx_i == CfgFramePixels)
    |=> info.pix == '0 && info.first_plane)
    else $error("counters not cleared by register write");

  // A new result only follows a last-plane transaction leaving the input stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q ##1 out_valid_q |-> $past(s1_adv && s1_info_q.last_plane))
    else $error("result raised without a last-plane transaction");

  // A pending result that is not taken blocks a last-plane transaction
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && s1_valid_q && s1_info_q.last_plane |-> !s1_adv)
    else $error("last-plane transaction overran a pending result");

endmodule

`default_nettype wire
